// ----- src/ffha_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, codes and defaults shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int unsigned DEF_POOL_WORDS   = 4096;
    localparam int unsigned DEF_HEADER_BYTES = 20;

    // Largest request that allocate accepts, in bytes.
    localparam int unsigned MAX_REQUEST = 16384;

    // Width that holds the word count of the largest request.
    localparam int unsigned REQ_WORDS_W = 13;

    localparam logic [31:0] POOL_END_RESET = 32'd16384;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MARK_NONE = 2'd0,
        MARK_FREE = 2'd1,
        MARK_BUSY = 2'd2
    } t_mark;

    typedef enum logic [0:0] {
        REG_POOL_START = 1'b0,
        REG_POOL_END   = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_BASE,
        S_INIT_SPAN,
        S_INIT_WR,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_ALLOC_SPLIT,
        S_FREE_RD,
        S_FREE_CHK,
        S_FREE_NXT,
        S_FREE_NXT_RD,
        S_FREE_NXT_CHK
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [14:0] request_bytes;
        logic [31:0] block_address;
    } t_heap_cmd;

    typedef struct packed {
        logic [31:0] value;
        logic        ok;
    } t_heap_res;

endpackage : ffha_pkg
`default_nettype wire

// ----- src/first_fit_heap_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with coalescing over a word-addressed header store.
// ----------------------------------------------------------------------------
// A command word is taken when i_start is high while o_busy is low; exactly
// one result word follows, shown for a single cycle with o_done, and the
// receiver cannot stall it. Init rounds the pool start, computes the span
// and writes one free header if the span holds one. Allocate and free walk
// the block chain in address order through one read port of the header
// store, reading one header per block visited, then update headers.
// Commands that fail their checks at once (pool not ready, request too
// large, unused code) return their result straight from idle.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int unsigned POOL_WORDS   = DEF_POOL_WORDS,
    parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire t_heap_cmd   i_cmd,
    output logic             o_done,
    output t_heap_res        o_res,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    localparam int unsigned HDR_WORDS = (HEADER_BYTES + 3) / 4;
    localparam int unsigned AW        = $clog2(POOL_WORDS);
    localparam int unsigned IDX_W     = $clog2(POOL_WORDS + 1);
    localparam int unsigned LEN_W     = AW;
    localparam int unsigned CW        = ((IDX_W > REQ_WORDS_W) ? IDX_W : REQ_WORDS_W) + 1;
    localparam int unsigned MW        = 2 + LEN_W;

    // Header store: mark and data length of the block whose header is there.
    logic [MW-1:0] mem [POOL_WORDS];

    logic [31:0]      r_pool_start, r_pool_end;
    t_state           r_state, n_state;
    logic             r_ready, n_ready;
    logic [31:0]      r_base, n_base;
    logic [IDX_W-1:0] r_span, n_span;
    logic [32:0]      r_s, n_s;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [IDX_W-1:0] r_prev, n_prev;
    logic             r_have_prev, n_have_prev;
    t_mark            r_prev_mark, n_prev_mark;
    logic [LEN_W-1:0] r_prev_len, n_prev_len;
    logic [LEN_W-1:0] r_cur_len, n_cur_len;
    logic [CW-1:0]    r_words, n_words;
    logic [CW-1:0]    r_need, n_need;
    logic [LEN_W-1:0] r_split_len, n_split_len;
    logic [31:0]      r_addr, n_addr;
    logic [MW-1:0]    r_rd;
    logic             r_done, n_done;
    t_heap_res        r_res, n_res;

    logic             w_en;
    logic [IDX_W-1:0] w_addr;
    logic [MW-1:0]    w_data;

    logic             accept;
    t_mark            rd_mark;
    logic [LEN_W-1:0] rd_len;
    logic [IDX_W:0]   next_sum;
    logic [IDX_W-1:0] next_idx;
    logic [31:0]      daddr;
    logic [33:0]      span_q;
    logic [IDX_W-1:0] span_val;
    logic [15:0]      req_plus;

    assign accept   = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_res    = r_res;
    assign o_pready = 1'b1;

    assign rd_mark  = t_mark'(r_rd[MW-1 -: 2]);
    assign rd_len   = r_rd[LEN_W-1:0];
    assign next_sum = (IDX_W+1)'(r_idx) + (IDX_W+1)'(HDR_WORDS) + (IDX_W+1)'(rd_len);
    assign next_idx = next_sum[IDX_W-1:0];
    assign daddr    = r_base + {(30)'(r_idx + IDX_W'(HDR_WORDS)), 2'b00};
    assign req_plus = 16'(i_cmd.request_bytes) + 16'd3;

    // Span in words: the end minus the rounded start, rounded up, capped.
    always_comb begin
        span_q   = '0;
        span_val = '0;
        if ({1'b0, r_pool_end} > r_s) begin
            span_q = (34'({1'b0, r_pool_end}) - 34'(r_s) + 34'd3) >> 2;
        end
        if (span_q > 34'(POOL_WORDS)) begin
            span_val = IDX_W'(POOL_WORDS);
        end else begin
            span_val = IDX_W'(span_q);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_start <= '0;
            r_pool_end   <= POOL_END_RESET;
        end else if (i_psel && i_penable && i_pwrite && o_pready) begin
            unique case (t_reg'(i_paddr[2]))
                REG_POOL_START: r_pool_start <= i_pwdata;
                REG_POOL_END:   r_pool_end   <= i_pwdata;
                default:        r_pool_end   <= r_pool_end;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(i_paddr[2]))
            REG_POOL_START: o_prdata = r_pool_start;
            REG_POOL_END:   o_prdata = r_pool_end;
            default:        o_prdata = '0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_cmd.cmd))
                        CMD_INIT:  n_state = S_INIT_BASE;
                        CMD_ALLOC: n_state = (r_ready && (i_cmd.request_bytes <=
                                              15'(MAX_REQUEST))) ? S_ALLOC_RD : S_IDLE;
                        CMD_FREE:  n_state = r_ready ? S_FREE_RD : S_IDLE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_INIT_BASE:   n_state = S_INIT_SPAN;
            S_INIT_SPAN:   n_state = S_INIT_WR;
            S_INIT_WR:     n_state = S_IDLE;
            S_ALLOC_RD:    n_state = S_ALLOC_CHK;
            S_ALLOC_CHK: begin
                if (rd_mark == MARK_FREE && CW'(rd_len) >= r_need) begin
                    n_state = S_ALLOC_SPLIT;
                end else if (next_idx >= r_span) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ALLOC_RD;
                end
            end
            S_ALLOC_SPLIT: n_state = S_IDLE;
            S_FREE_RD:     n_state = S_FREE_CHK;
            S_FREE_CHK: begin
                if (daddr == r_addr) begin
                    n_state = (rd_mark == MARK_BUSY) ? S_FREE_NXT : S_IDLE;
                end else if (next_idx >= r_span) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FREE_RD;
                end
            end
            S_FREE_NXT:     n_state = (n_ptr >= r_span) ? S_IDLE : S_FREE_NXT_RD;
            S_FREE_NXT_RD:  n_state = S_FREE_NXT_CHK;
            S_FREE_NXT_CHK: n_state = S_IDLE;
            default:        n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        logic [IDX_W:0] cur_next;
        n_ready     = r_ready;
        n_base      = r_base;
        n_span      = r_span;
        n_s         = r_s;
        n_idx       = r_idx;
        n_ptr       = r_ptr;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_prev_mark = r_prev_mark;
        n_prev_len  = r_prev_len;
        n_cur_len   = r_cur_len;
        n_words     = r_words;
        n_need      = r_need;
        n_split_len = r_split_len;
        n_addr      = r_addr;
        n_done      = 1'b0;
        n_res       = '0;
        w_en        = 1'b0;
        w_addr      = r_idx;
        w_data      = '0;
        cur_next    = (IDX_W+1)'(r_idx) + (IDX_W+1)'(HDR_WORDS) + (IDX_W+1)'(r_cur_len);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_words     = CW'(req_plus[15:2]);
                    n_need      = CW'(req_plus[15:2]) + CW'(HDR_WORDS);
                    n_addr      = i_cmd.block_address;
                    n_idx       = '0;
                    n_ptr       = '0;
                    n_have_prev = 1'b0;
                    if (n_state == S_IDLE) begin
                        n_done = 1'b1;
                    end
                end
            end
            S_INIT_BASE: begin
                n_s = ({1'b0, r_pool_start} + 33'd3) & ~33'd3;
            end
            S_INIT_SPAN: begin
                n_span = span_val;
            end
            S_INIT_WR: begin
                n_done = 1'b1;
                if (r_span < IDX_W'(HDR_WORDS)) begin
                    n_ready = 1'b0;
                end else begin
                    n_ready     = 1'b1;
                    n_base      = r_s[31:0];
                    w_en        = 1'b1;
                    w_addr      = '0;
                    w_data      = {MARK_FREE, LEN_W'(r_span - IDX_W'(HDR_WORDS))};
                    n_res.ok    = 1'b1;
                    n_res.value = 32'({r_span, 2'b00});
                end
            end
            S_ALLOC_CHK: begin
                if (rd_mark == MARK_FREE && CW'(rd_len) >= r_need) begin
                    w_en        = 1'b1;
                    w_addr      = r_idx;
                    w_data      = {MARK_BUSY, LEN_W'(r_words)};
                    n_ptr       = IDX_W'(CW'(r_idx) + CW'(HDR_WORDS) + r_words);
                    n_split_len = LEN_W'(CW'(rd_len) - r_need);
                end else if (next_idx >= r_span) begin
                    n_done = 1'b1;
                end else begin
                    n_idx = next_idx;
                    n_ptr = next_idx;
                end
            end
            S_ALLOC_SPLIT: begin
                // The remainder may hold no data words at all.
                w_en        = 1'b1;
                w_addr      = r_ptr;
                w_data      = {MARK_FREE, r_split_len};
                n_done      = 1'b1;
                n_res.ok    = 1'b1;
                n_res.value = daddr;
            end
            S_FREE_CHK: begin
                if (daddr == r_addr) begin
                    if (rd_mark != MARK_BUSY) begin
                        n_done = 1'b1;
                    end else if (r_have_prev && r_prev_mark == MARK_FREE) begin
                        // The freed header is absorbed by the block before it.
                        n_cur_len = r_prev_len + LEN_W'(HDR_WORDS) + rd_len;
                        w_en      = 1'b1;
                        w_addr    = r_prev;
                        w_data    = {MARK_FREE, n_cur_len};
                        n_idx     = r_prev;
                    end else begin
                        n_cur_len = rd_len;
                        w_en      = 1'b1;
                        w_addr    = r_idx;
                        w_data    = {MARK_FREE, rd_len};
                    end
                end else if (next_idx >= r_span) begin
                    n_done = 1'b1;
                end else begin
                    n_prev      = r_idx;
                    n_have_prev = 1'b1;
                    n_prev_mark = rd_mark;
                    n_prev_len  = rd_len;
                    n_idx       = next_idx;
                    n_ptr       = next_idx;
                end
            end
            S_FREE_NXT: begin
                n_ptr = cur_next[IDX_W-1:0];
                if (n_ptr >= r_span) begin
                    n_done   = 1'b1;
                    n_res.ok = 1'b1;
                end
            end
            S_FREE_NXT_CHK: begin
                if (rd_mark == MARK_FREE) begin
                    w_en   = 1'b1;
                    w_addr = r_idx;
                    w_data = {MARK_FREE, r_cur_len + LEN_W'(HDR_WORDS) + rd_len};
                end
                n_done   = 1'b1;
                n_res.ok = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr[AW-1:0]] <= w_data;
        end
        r_rd <= mem[r_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_done  <= 1'b0;
            r_base  <= '0;
            r_span  <= '0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_done  <= n_done;
            r_base  <= n_base;
            r_span  <= n_span;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s         <= n_s;
        r_idx       <= n_idx;
        r_ptr       <= n_ptr;
        r_prev      <= n_prev;
        r_have_prev <= n_have_prev;
        r_prev_mark <= n_prev_mark;
        r_prev_len  <= n_prev_len;
        r_cur_len   <= n_cur_len;
        r_words     <= n_words;
        r_need      <= n_need;
        r_split_len <= n_split_len;
        r_addr      <= n_addr;
        r_res       <= n_res;
    end

endmodule : first_fit_heap_allocator
`default_nettype wire
